@@ rtl/core/clcg_pkg.sv @@
// shared types and constants of the combined lcg / xorshift / mwc generator
package clcg_pkg;

    localparam logic [63:0] LCG_MUL = 64'd2862933555777941757;
    localparam logic [63:0] LCG_ADD = 64'd7046029254386353087;
    localparam logic [31:0] MWC_MUL = 32'd4294957665;
    localparam logic [63:0] XS_INIT = 64'd4101842887655102017;

    localparam logic [31:0] LCG_MUL_LO = LCG_MUL[31:0];
    localparam logic [31:0] LCG_MUL_HI = LCG_MUL[63:32];

    // warm-up step numbers of a seed item
    localparam logic [1:0] WARM_FIRST  = 2'd0;
    localparam logic [1:0] WARM_SECOND = 2'd1;
    localparam logic [1:0] WARM_LAST   = 2'd2;

    // action codes
    localparam logic ACT_SEED = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_UPD,
        ST_OUT
    } state_t;

    // operand pair fed to the shared multiplier
    typedef enum logic [1:0] {
        OP_ULO_CLO,
        OP_UHI_CLO,
        OP_ULO_CHI,
        OP_WLO_MWC
    } op_sel_t;

    typedef struct packed {
        op_sel_t op_sel;
        logic    in_ready;
        logic    seed_load;
        logic    acc_load;
        logic    acc_add;
        logic    upd;
        logic    copy_xs;
        logic    copy_mwc;
        logic    out_load;
    } ctrl_t;

endpackage

@@ rtl/core/clcg_mul32.sv @@
// shared 32x32 unsigned multiplier with registered product
module clcg_mul32 (
    input  logic        aclk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] prod
);

    logic [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(op_a) * 64'(op_b);
    end

    assign prod = prod_reg;

endmodule

@@ rtl/core/clcg_seq.sv @@
// sequencer that steps the shared multiplier through one generator step, or three warm-up steps for a seed
module clcg_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic              in_action,
    input  logic              out_free,
    output clcg_pkg::ctrl_t   ctrl
);

    clcg_pkg::state_t state_reg, state_next;
    logic [1:0]       warm_reg, warm_next;
    logic             seeding_reg, seeding_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= clcg_pkg::ST_IDLE;
            warm_reg    <= clcg_pkg::WARM_FIRST;
            seeding_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            warm_reg    <= warm_next;
            seeding_reg <= seeding_next;
        end
    end

    // next state
    always_comb begin
        state_next   = state_reg;
        warm_next    = warm_reg;
        seeding_next = seeding_reg;
        case (state_reg)
            clcg_pkg::ST_IDLE: begin
                if (in_valid) begin
                    state_next   = clcg_pkg::ST_MUL0;
                    warm_next    = clcg_pkg::WARM_FIRST;
                    seeding_next = (in_action == clcg_pkg::ACT_SEED);
                end
            end
            clcg_pkg::ST_MUL0: state_next = clcg_pkg::ST_MUL1;
            clcg_pkg::ST_MUL1: state_next = clcg_pkg::ST_MUL2;
            clcg_pkg::ST_MUL2: state_next = clcg_pkg::ST_MUL3;
            clcg_pkg::ST_MUL3: state_next = clcg_pkg::ST_UPD;
            clcg_pkg::ST_UPD: begin
                if (!seeding_reg) begin
                    state_next = clcg_pkg::ST_OUT;
                end else if (warm_reg == clcg_pkg::WARM_LAST) begin
                    state_next = clcg_pkg::ST_IDLE;
                end else begin
                    state_next = clcg_pkg::ST_MUL0;
                    warm_next  = warm_reg + 2'd1;
                end
            end
            clcg_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = clcg_pkg::ST_IDLE;
                end
            end
            default: state_next = clcg_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        ctrl           = '0;
        ctrl.op_sel    = clcg_pkg::OP_ULO_CLO;
        case (state_reg)
            clcg_pkg::ST_IDLE: begin
                ctrl.in_ready  = 1'b1;
                ctrl.seed_load = in_valid && (in_action == clcg_pkg::ACT_SEED);
            end
            clcg_pkg::ST_MUL0: ctrl.op_sel = clcg_pkg::OP_ULO_CLO;
            clcg_pkg::ST_MUL1: begin
                ctrl.op_sel   = clcg_pkg::OP_UHI_CLO;
                ctrl.acc_load = 1'b1;
            end
            clcg_pkg::ST_MUL2: begin
                ctrl.op_sel  = clcg_pkg::OP_ULO_CHI;
                ctrl.acc_add = 1'b1;
            end
            clcg_pkg::ST_MUL3: begin
                ctrl.op_sel  = clcg_pkg::OP_WLO_MWC;
                ctrl.acc_add = 1'b1;
            end
            clcg_pkg::ST_UPD: begin
                ctrl.upd      = 1'b1;
                ctrl.copy_xs  = seeding_reg && (warm_reg == clcg_pkg::WARM_FIRST);
                ctrl.copy_mwc = seeding_reg && (warm_reg == clcg_pkg::WARM_SECOND);
            end
            clcg_pkg::ST_OUT: ctrl.out_load = out_free;
            default: ctrl = '0;
        endcase
    end

endmodule

@@ rtl/core/combined_lcg_xorshift_mwc_prng_core.sv @@
// top level of the combined lcg / xorshift / mwc generator: state words, datapath, stream ports
// output item: accepted in idle, then mul0 to mul3 and upd; result register loads in out once free
// seed item: 3 warm-up steps, each through mul0 to mul3 and upd, then idle again with no output
// items are taken only in idle; one shared 32x32 multiplier forms the four products of each step
// a finished item may wait in the output register while the next item is taken
// synchronous active-low reset: lcg word 0, xorshift word 4101842887655102017, mwc word 1
module combined_lcg_xorshift_mwc_prng_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] seed_value
    input  logic [0:0]  s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [63:0] random_word
);

    clcg_pkg::ctrl_t ctrl;

    // generator state
    logic [63:0] lcg_reg, lcg_next;
    logic [63:0] xs_reg, xs_next;
    logic [63:0] mwc_reg, mwc_next;

    // partial sum of the 64-bit lcg product
    logic [63:0] acc_reg;

    // output register
    logic [63:0] out_reg;
    logic        out_valid_reg;
    logic        out_free;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    logic [63:0] lcg_step, xs_a, xs_b, xs_step, mwc_step;
    logic [63:0] scr_a, scr_b, scr_c, result;

    assign out_free = !out_valid_reg || m_tready;

    clcg_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_action (s_tuser[0]),
        .out_free  (out_free),
        .ctrl      (ctrl)
    );

    // operand select for the shared multiplier
    // lcg word times constant mod 2^64 = lo*lo + ((hi*lo + lo*hi) << 32)
    always_comb begin
        case (ctrl.op_sel)
            clcg_pkg::OP_ULO_CLO: begin
                mul_a = lcg_reg[31:0];
                mul_b = clcg_pkg::LCG_MUL_LO;
            end
            clcg_pkg::OP_UHI_CLO: begin
                mul_a = lcg_reg[63:32];
                mul_b = clcg_pkg::LCG_MUL_LO;
            end
            clcg_pkg::OP_ULO_CHI: begin
                mul_a = lcg_reg[31:0];
                mul_b = clcg_pkg::LCG_MUL_HI;
            end
            clcg_pkg::OP_WLO_MWC: begin
                mul_a = mwc_reg[31:0];
                mul_b = clcg_pkg::MWC_MUL;
            end
            default: begin
                mul_a = lcg_reg[31:0];
                mul_b = clcg_pkg::LCG_MUL_LO;
            end
        endcase
    end

    clcg_mul32 u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // low-by-low product lands first, the two cross terms only touch the upper half
    always_ff @(posedge aclk) begin
        if (ctrl.acc_load) begin
            acc_reg <= prod;
        end else if (ctrl.acc_add) begin
            acc_reg[63:32] <= acc_reg[63:32] + prod[31:0];
        end
    end

    // one step of all three words; the mwc product is on the multiplier output in the update cycle
    always_comb begin
        lcg_step = acc_reg + clcg_pkg::LCG_ADD;
        xs_a     = xs_reg ^ (xs_reg >> 17);
        xs_b     = xs_a ^ (xs_a << 31);
        xs_step  = xs_b ^ (xs_b >> 8);
        mwc_step = prod + {32'd0, mwc_reg[63:32]};
    end

    always_comb begin
        lcg_next = lcg_reg;
        xs_next  = xs_reg;
        mwc_next = mwc_reg;
        if (ctrl.seed_load) begin
            // zero seed falls back to the fixed constant
            lcg_next = (s_tdata != 64'd0) ? s_tdata : clcg_pkg::XS_INIT;
            xs_next  = clcg_pkg::XS_INIT;
            mwc_next = 64'd1;
        end else if (ctrl.upd) begin
            lcg_next = lcg_step;
            // warm-up copies: after the first step xorshift takes the lcg word,
            // after the second mwc takes the xorshift word
            xs_next  = ctrl.copy_xs ? lcg_step : xs_step;
            mwc_next = ctrl.copy_mwc ? xs_step : mwc_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcg_reg <= 64'd0;
            xs_reg  <= clcg_pkg::XS_INIT;
            mwc_reg <= 64'd1;
        end else begin
            lcg_reg <= lcg_next;
            xs_reg  <= xs_next;
            mwc_reg <= mwc_next;
        end
    end

    // output scramble of the lcg word, combined with the other two words
    always_comb begin
        scr_a  = lcg_reg ^ (lcg_reg << 21);
        scr_b  = scr_a ^ (scr_a >> 35);
        scr_c  = scr_b ^ (scr_b << 4);
        result = (scr_c + xs_reg) ^ mwc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            out_reg <= result;
        end
    end

    // no item is taken while reset is held
    assign s_tready = ctrl.in_ready && aresetn;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // busy for the whole step once an item is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a step is still running");

    // accumulator, update and output load never overlap
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({ctrl.acc_load, ctrl.acc_add, ctrl.upd, ctrl.out_load, ctrl.seed_load}))
        else $error("overlapping datapath controls");

    // a result shows up only from an output load
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(ctrl.out_load))
        else $error("result valid without an output load");

    // warm-up copies happen only in an update cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.copy_xs || ctrl.copy_mwc) |-> ctrl.upd)
        else $error("warm-up copy outside an update cycle");

endmodule
